// ----- hdl/pva_pkg.sv -----
`default_nettype none
package pva_pkg;
    localparam int NUM_VOICES = 16;
    localparam int NUM_KEYS   = 88;
    localparam int VW = $clog2(NUM_VOICES);
    localparam int LW = VW + 1;
    localparam int KW = 7;
    localparam int CW = $clog2(NUM_VOICES + 1);
    localparam int QD = 2;
    localparam logic [LW-1:0] NIL = LW'(NUM_VOICES);
    localparam logic [6:0] LOWEST_NOTE_RST = 7'd21;

    localparam logic [1:0] FUNC_ON   = 2'd0;
    localparam logic [1:0] FUNC_OFF  = 2'd1;
    localparam logic [1:0] FUNC_IDLE = 2'd2;

    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_STEAL   = 3'd1;
    localparam logic [2:0] ACT_RETRIG  = 3'd2;
    localparam logic [2:0] ACT_RELEASE = 3'd3;
    localparam logic [2:0] ACT_IGNORE  = 3'd4;
    localparam logic [2:0] ACT_FREE    = 3'd5;

    localparam logic [0:0] REG_LOWEST_NOTE = 1'd0;

    typedef struct packed {
        logic [1:0]  func;
        logic [6:0]  midi_note;
        logic [15:0] velocity;
        logic [3:0]  voice_id;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  result_voice;
        logic [2:0]  action;
        logic [6:0]  evicted_key;
        logic [15:0] start_velocity;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_NONE, CMD_ON, CMD_OFF, CMD_IDLE
    } t_cmd;

    typedef enum logic {
        BS_FETCH, BS_EXEC
    } t_bstate;

    typedef struct packed {
        t_cmd        cmd;
        logic [KW-1:0] key;
        logic [15:0] velocity;
        logic [VW-1:0] voice;
    } t_cmd_item;
endpackage
`default_nettype wire

// ----- hdl/pva_front.sv -----
`default_nettype none
module pva_front
    import pva_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire logic      i_push,
    output logic           o_full,
    input  wire logic [6:0] i_lowest_note,
    output t_cmd_item      o_cmd,
    output logic           o_cmd_valid,
    input  wire logic      i_cmd_take
);
    t_cmd_item r_q [QD];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd_item w_c;
    logic [7:0] w_diff;
    logic w_key_ok;

    always_comb begin
        w_diff   = {1'b0, i_item.midi_note} - {1'b0, i_lowest_note};
        w_key_ok = !w_diff[7] && (w_diff < 8'(NUM_KEYS));
        w_c.key      = w_diff[KW-1:0];
        w_c.velocity = i_item.velocity;
        w_c.voice    = i_item.voice_id[VW-1:0];
        case (i_item.func)
            FUNC_ON:   w_c.cmd = w_key_ok ? CMD_ON : CMD_NONE;
            FUNC_OFF:  w_c.cmd = w_key_ok ? CMD_OFF : CMD_NONE;
            FUNC_IDLE: w_c.cmd = CMD_IDLE;
            default:   w_c.cmd = CMD_NONE;
        endcase
    end

    assign o_full      = (r_cnt == 2'(QD));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_q[r_wp] <= w_c;
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_take && o_cmd_valid) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_cmd_take && o_cmd_valid);
        end
    end
endmodule
`default_nettype wire

// ----- hdl/pva_back.sv -----
`default_nettype none
module pva_back
    import pva_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd_item i_cmd,
    input  wire logic      i_cmd_valid,
    output logic           o_cmd_take,
    output t_out_item      o_item,
    output logic           o_empty,
    input  wire logic      i_pop
);
    logic [VW-1:0] r_kmap [NUM_KEYS];
    logic [VW-1:0] r_kmap_q;
    t_cmd_item r_cmd;
    t_bstate r_state, n_state;
    logic w_exec;
    logic [NUM_KEYS-1:0] r_kval, n_kval;
    logic [KW-1:0] r_vkey [NUM_VOICES];
    logic [KW-1:0] n_vkey [NUM_VOICES];
    logic [LW-1:0] r_next [NUM_VOICES];
    logic [LW-1:0] n_next [NUM_VOICES];
    logic [LW-1:0] r_prev [NUM_VOICES];
    logic [LW-1:0] n_prev [NUM_VOICES];
    logic [VW-1:0] r_fstk [NUM_VOICES];
    logic [VW-1:0] n_fstk [NUM_VOICES];
    logic [NUM_VOICES-1:0] r_fset, n_fset;
    logic [CW-1:0] r_fcnt, n_fcnt;
    logic [LW-1:0] r_head, r_tail, n_head, n_tail;
    logic [NUM_VOICES-1:0] r_busy, n_busy;
    logic r_ovalid;
    t_out_item r_out, n_out;
    logic n_kmap_we;
    logic [VW-1:0] w_v;

    assign o_empty = !r_ovalid;
    assign o_item  = r_out;

    always_comb begin
        case (r_state)
            BS_FETCH: n_state = i_cmd_valid ? BS_EXEC : BS_FETCH;
            BS_EXEC:  n_state = (!r_ovalid || i_pop) ? BS_FETCH : BS_EXEC;
            default:  n_state = BS_FETCH;
        endcase
    end

    always_comb begin
        o_cmd_take = 1'b0;
        w_exec     = 1'b0;
        case (r_state)
            BS_FETCH: o_cmd_take = i_cmd_valid;
            BS_EXEC:  w_exec = !r_ovalid || i_pop;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= BS_FETCH;
        else r_state <= n_state;
    end

    // Execute step: a busy voice always owns the key it records, so that key is unmapped
    // directly on steal and idle. List edit: optional remove, then optional insert at tail or head.
    always_comb begin
        logic [VW-1:0] v, fv;
        logic [KW-1:0] old;
        logic [LW-1:0] p, nx;
        logic do_rm, do_tail, do_front;
        n_vkey = r_vkey; n_next = r_next; n_prev = r_prev; n_fstk = r_fstk;
        n_fset = r_fset; n_busy = r_busy; n_kval = r_kval; n_fcnt = r_fcnt;
        n_head = r_head; n_tail = r_tail;
        n_kmap_we = 1'b0;
        n_out = '{result_voice: '0, action: ACT_IGNORE, evicted_key: '0,
                  start_velocity: '0};
        v = r_cmd.voice; do_rm = 1'b0; do_tail = 1'b0; do_front = 1'b0;
        p = '0; nx = '0;
        fv = r_fset[r_fcnt[VW-1:0]-VW'(1)] ? r_fstk[r_fcnt[VW-1:0]-VW'(1)]
                                           : (r_fcnt[VW-1:0]-VW'(1));
        old = r_vkey[r_head[VW-1:0]];
        case (r_cmd.cmd)
            CMD_ON: begin
                if (r_kval[r_cmd.key]) begin
                    n_out.result_voice = 4'(r_kmap_q);
                    n_out.action = ACT_RETRIG;
                    n_out.start_velocity = r_cmd.velocity;
                end else if (r_fcnt != '0 || r_head != NIL) begin
                    if (r_fcnt != '0) begin
                        v = fv; n_fcnt = r_fcnt - 1'b1;
                        n_out.action = ACT_START;
                    end else begin
                        v = r_head[VW-1:0]; do_rm = 1'b1;
                        n_kval[old] = 1'b0;
                        n_out.evicted_key = old;
                        n_out.action = ACT_STEAL;
                    end
                    do_tail = 1'b1;
                    n_vkey[v] = r_cmd.key;
                    n_kmap_we = 1'b1;
                    n_kval[r_cmd.key] = 1'b1;
                    n_busy[v] = 1'b1;
                    n_out.result_voice = 4'(v);
                    n_out.start_velocity = r_cmd.velocity;
                end
            end
            CMD_OFF: begin
                if (r_kval[r_cmd.key]) begin
                    v = r_kmap_q;
                    if (r_head != {1'b0, v}) begin
                        do_rm = 1'b1; do_front = 1'b1;
                    end
                    n_out.result_voice = 4'(v);
                    n_out.action = ACT_RELEASE;
                end
            end
            CMD_IDLE: begin
                if (r_busy[v]) begin
                    n_kval[r_vkey[v]] = 1'b0;
                    do_rm = 1'b1;
                    n_busy[v] = 1'b0;
                    if (r_fcnt < CW'(NUM_VOICES)) begin
                        n_fstk[r_fcnt[VW-1:0]] = v;
                        n_fset[r_fcnt[VW-1:0]] = 1'b1;
                        n_fcnt = r_fcnt + 1'b1;
                    end
                    n_out.result_voice = 4'(v);
                    n_out.action = ACT_FREE;
                end
            end
            default: ;
        endcase
        if (do_rm) begin
            p = n_prev[v]; nx = n_next[v];
            if (p != NIL) n_next[p[VW-1:0]] = nx; else n_head = nx;
            if (nx != NIL) n_prev[nx[VW-1:0]] = p; else n_tail = p;
        end
        if (do_tail) begin
            n_next[v] = NIL; n_prev[v] = n_tail;
            if (n_tail != NIL) n_next[n_tail[VW-1:0]] = {1'b0, v}; else n_head = {1'b0, v};
            n_tail = {1'b0, v};
        end
        if (do_front) begin
            n_prev[v] = NIL; n_next[v] = n_head;
            if (n_head != NIL) n_prev[n_head[VW-1:0]] = {1'b0, v}; else n_tail = {1'b0, v};
            n_head = {1'b0, v};
        end
        w_v = v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kval <= '0; r_fset <= '0; r_fcnt <= CW'(NUM_VOICES);
            r_head <= NIL; r_tail <= NIL; r_busy <= '0; r_ovalid <= 1'b0;
        end else if (w_exec) begin
            r_kval <= n_kval; r_fset <= n_fset; r_fcnt <= n_fcnt;
            r_head <= n_head; r_tail <= n_tail; r_busy <= n_busy;
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    // key map: registered read at fetch, write at execute
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd    <= i_cmd;
            r_kmap_q <= r_kmap[i_cmd.key];
        end
        if (w_exec) begin
            r_vkey <= n_vkey; r_next <= n_next; r_prev <= n_prev; r_fstk <= n_fstk;
            r_out  <= n_out;
            if (n_kmap_we) r_kmap[r_cmd.key] <= w_v;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/poly_voice_allocator_unit.sv -----
// Path from an accepted item to the output ports, each step registered: queue write,
// key map read, execute.
// The back reads the key map in its fetch state and updates all voice state in its
// execute state, taking no new item meanwhile. A waiting result holds the back in execute.
// A two-entry queue between classify and allocate lets each side stall on its own.
// Reset (synchronous, active low): all keys unmapped, all voices free, list empty,
// lowest_note 21. No clearing pass is needed.
`default_nettype none
module poly_voice_allocator_unit
    import pva_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_in_item    i_item,
    input  wire logic        push,
    output logic             full,
    output t_out_item        o_item,
    output logic             empty,
    input  wire logic        pop,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [6:0] r_lowest;
    t_cmd_item w_cmd;
    logic w_cv, w_take;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == {REG_LOWEST_NOTE, 1'b0}) ? {25'd0, r_lowest} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lowest <= LOWEST_NOTE_RST;
        else if (psel && penable && pwrite && paddr == {REG_LOWEST_NOTE, 1'b0})
            r_lowest <= pwdata[6:0];
    end

    pva_front u_front (
        .i_clk, .i_rst_n, .i_item, .i_push(push), .o_full(full),
        .i_lowest_note(r_lowest), .o_cmd(w_cmd), .o_cmd_valid(w_cv), .i_cmd_take(w_take)
    );

    pva_back u_back (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_cmd_valid(w_cv), .o_cmd_take(w_take),
        .o_item, .o_empty(empty), .i_pop(pop)
    );
endmodule
`default_nettype wire
